// ===== rtl/afwg_pkg.sv =====
package afwg_pkg;

   // Geometry limits of the detector and the volume
   localparam int DETECTOR_ROWS = 1024;
   localparam int MAX_RUN       = 32;
   localparam int U_BINS        = 1024;
   localparam int SLICES        = 1024;
   localparam int RESULT_CAP    = 32;
   localparam int RUN_CAP       = (MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP;

   // Port widths
   localparam int COL_W     = 10;
   localparam int ROW_W     = 10;
   localparam int WEIGHT_W  = 8;
   localparam int CFG_W     = 32;
   localparam int CFG_IDX_W = 3;

   // Shared divider and square root widths
   localparam int DIV_DVD_W = 64;
   localparam int DIV_DVS_W = 32;
   localparam int SQRT_RAD_W = 64;

   // Register indexes
   localparam logic [CFG_IDX_W-1:0] REG_U_REL_ORIGIN  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_DELTA_U       = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_SRC_DET_DIST  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN      = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_DELTA_Z       = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_W_FIRST_CTR   = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_DELTA_DW      = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GAIN   = 3'd7;

   // Datapath commands
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
   localparam logic [OP_W-1:0] OP_CALC0  = 5'd2;
   localparam logic [OP_W-1:0] OP_CALC1  = 5'd3;
   localparam logic [OP_W-1:0] OP_MUL    = 5'd4;
   localparam logic [OP_W-1:0] OP_SQ     = 5'd5;
   localparam logic [OP_W-1:0] OP_DIV_C  = 5'd6;
   localparam logic [OP_W-1:0] OP_TAKE_C = 5'd7;
   localparam logic [OP_W-1:0] OP_DIV_W  = 5'd8;
   localparam logic [OP_W-1:0] OP_TAKE_W = 5'd9;
   localparam logic [OP_W-1:0] OP_NUM    = 5'd10;
   localparam logic [OP_W-1:0] OP_DIV_S  = 5'd11;
   localparam logic [OP_W-1:0] OP_TAKE_S = 5'd12;
   localparam logic [OP_W-1:0] OP_DIV_P  = 5'd13;
   localparam logic [OP_W-1:0] OP_TAKE_P = 5'd14;
   localparam logic [OP_W-1:0] OP_RANGE  = 5'd15;
   localparam logic [OP_W-1:0] OP_SQRT   = 5'd16;
   localparam logic [OP_W-1:0] OP_DIV_F  = 5'd17;
   localparam logic [OP_W-1:0] OP_TAKE_F = 5'd18;
   localparam logic [OP_W-1:0] OP_GAIN   = 5'd19;
   localparam logic [OP_W-1:0] OP_PCAP   = 5'd20;
   localparam logic [OP_W-1:0] OP_ROW    = 5'd21;
   localparam logic [OP_W-1:0] OP_PMUL   = 5'd22;
   localparam logic [OP_W-1:0] OP_EMIT   = 5'd23;
   localparam logic [OP_W-1:0] OP_EMPTY  = 5'd24;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      pp;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic div_done;
      logic sqrt_done;
      logic range_empty;
      logic last_row;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/axial_footprint_weight_generator_unit.sv =====
// Throughput: one item at a time; five 64-step divisions on the shared one-bit-a-cycle
//    divider and the 32-step square root set the time per item.
// Reset: synchronous, active high; configuration registers return to their defaults and the block idles.
module axial_footprint_weight_generator_unit #(
   parameter int DETECTOR_ROWS = afwg_pkg::DETECTOR_ROWS,
   parameter int MAX_RUN       = afwg_pkg::MAX_RUN,
   parameter int U_BINS        = afwg_pkg::U_BINS,
   parameter int SLICES        = afwg_pkg::SLICES
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // Voxel words in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] voxel_column, [19:10] voxel_slice, rest zero
   // Row weight words out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] detector_row, [17:10] weight, rest zero
   output logic        rsp_tuser,   // [0] empty_res
   output logic        rsp_tlast
);

   afwg_pkg::cmd_type    cmd;
   afwg_pkg::status_type st;
   logic [9:0]           rsp_row;
   logic [7:0]           rsp_weight;

   // Sequencer: walks the geometry, bounds, obliquity and per-row weights
   afwg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   // Arithmetic, shared divider and square root, output register
   afwg_datapath #(
      .DETECTOR_ROWS (DETECTOR_ROWS),
      .MAX_RUN       (MAX_RUN),
      .U_BINS        (U_BINS),
      .SLICES        (SLICES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_col     (req_tdata[9:0]),
      .in_slice   (req_tdata[19:10]),
      .cmd        (cmd),
      .st         (st),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_row    (rsp_row),
      .rsp_weight (rsp_weight),
      .rsp_empty  (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, rsp_weight, rsp_row};

   // Hold off new words while an item is in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in flight");

   // An empty footprint closes its run with zero row and weight
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 24'd0))
      else $error("malformed empty result");

   // Never load the output register over a word that is still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == afwg_pkg::OP_EMIT || cmd.op == afwg_pkg::OP_EMPTY) |-> st.out_free)
      else $error("result overwritten before it was taken");

endmodule

// ===== rtl/afwg_divider.sv =====
module afwg_divider #(
   parameter int DVD_W = afwg_pkg::DIV_DVD_W,
   parameter int DVS_W = afwg_pkg::DIV_DVS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic             rem_nz
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic             ge;

   // One quotient bit a cycle; quotient bits shift into the dividend register
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      ge       = rem_sh >= {1'b0, dvs_ff};
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      done_in  = 1'b0;
      if (start) begin
         count_in = CNT_W'(DVD_W);
         dvd_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         rem_in   = ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
         dvd_in   = {dvd_ff[DVD_W-2:0], ge};
         count_in = count_ff - CNT_W'(1);
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
   assign rem_nz   = |rem_ff;

endmodule

// ===== rtl/afwg_isqrt.sv =====
module afwg_isqrt #(
   parameter int RAD_W = afwg_pkg::SQRT_RAD_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAD_W-1:0]   radicand,
   output logic               done,
   output logic [RAD_W/2-1:0] root
);

   localparam int RT_W  = RAD_W / 2;
   localparam int REM_W = RT_W + 4;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             ge;

   // Two radicand bits and one root bit a cycle
   always_comb begin
      rem_sh   = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial    = {2'b00, root_ff, 2'b01};
      ge       = rem_sh >= trial;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      if (start) begin
         count_in = CNT_W'(RT_W);
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (count_ff != '0) begin
         rem_in   = ge ? rem_sh - trial : rem_sh;
         root_in  = {root_ff[RT_W-2:0], ge};
         rad_in   = {rad_ff[RAD_W-3:0], 2'b00};
         count_in = count_ff - CNT_W'(1);
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/afwg_datapath.sv =====
module afwg_datapath #(
   parameter int DETECTOR_ROWS = afwg_pkg::DETECTOR_ROWS,
   parameter int MAX_RUN       = afwg_pkg::MAX_RUN,
   parameter int U_BINS        = afwg_pkg::U_BINS,
   parameter int SLICES        = afwg_pkg::SLICES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [afwg_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [afwg_pkg::CFG_W-1:0]       csr_wdata,
   input  logic [afwg_pkg::COL_W-1:0]       in_col,
   input  logic [afwg_pkg::COL_W-1:0]       in_slice,
   input  afwg_pkg::cmd_type                cmd,
   output afwg_pkg::status_type             st,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [afwg_pkg::ROW_W-1:0]       rsp_row,
   output logic [afwg_pkg::WEIGHT_W-1:0]    rsp_weight,
   output logic                             rsp_empty,
   output logic                             rsp_last
);

   localparam logic [63:0] SAT48 = 64'h0001_0000_0000_0000;
   localparam int RUN_CAP = (MAX_RUN < afwg_pkg::RESULT_CAP) ? MAX_RUN : afwg_pkg::RESULT_CAP;

   // Configuration
   logic signed [31:0] uro_ff, zo_ff, wfc_ff;
   logic [30:0]        du_cfg_ff, sdd_ff, dz_ff, dd_ff, gain_ff;

   // Per-item working registers
   logic [9:0]         col_ff, slice_ff;
   logic signed [42:0] du_raw_ff, wv_raw_ff;
   logic [30:0]        du_ff;
   logic signed [31:0] wv_ff;
   logic signed [63:0] prod_a_ff;
   logic [61:0]        prod_b_ff;
   logic [63:0]        sq_ff;
   logic               neg_ff;
   logic signed [49:0] c_ff;
   logic [48:0]        wid_ff;
   logic signed [52:0] num_s_ff, num_p_ff, start_ff, stop_ff;
   logic [9:0]         row_ff, end_ff;
   logic [47:0]        f_ff;
   logic [78:0]        gacc_ff;
   logic [40:0]        p41_ff, l2_ff;
   logic               p_sat_ff, p_zero_ff, l2_sat_ff, l2_zero_ff;
   logic [81:0]        macc_ff;
   logic               rsp_valid_ff;
   logic [9:0]         rsp_row_ff;
   logic [7:0]         rsp_weight_ff;
   logic               rsp_empty_ff, rsp_last_ff;

   // Shared units
   logic        div_start, div_done, div_rnz;
   logic [63:0] div_dvd, div_q;
   logic [31:0] div_dvs;
   logic        sqrt_done;
   logic [31:0] sqrt_root;

   afwg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q),
      .rem_nz   (div_rnz)
   );

   afwg_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == afwg_pkg::OP_SQRT),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Combinational helpers
   logic [40:0]        col_prod, slice_prod;
   logic signed [42:0] du_raw_in, wv_raw_in;
   logic signed [63:0] prod_a_in;
   logic [31:0]        wa;
   logic [63:0]        q_sel, q_inc, mag_c;
   logic [52:0]        q_m;
   logic signed [52:0] start_c, stop_c, span;
   logic [23:0]        g_sel;
   logic [54:0]        g_prod;
   logic signed [53:0] wd, diff, d2, b2, m, l2;
   logic [20:0]        pa, pb;
   logic [41:0]        m_prod;
   logic [81:0]        m_term;
   logic [82:0]        w_sum;
   logic [7:0]         weight_val;

   always_comb begin
      col_prod   = 41'(col_ff) * 41'(du_cfg_ff);
      slice_prod = 41'(slice_ff) * 41'(dz_ff);
      du_raw_in  = 43'(uro_ff) + $signed(43'(col_prod));
      wv_raw_in  = 43'(zo_ff) + $signed(43'(slice_prod)) + $signed(43'(dz_ff[30:1]));
      prod_a_in  = wv_ff * $signed({1'b0, sdd_ff});
      wa         = wv_ff[31] ? 32'(-wv_ff) : 32'(wv_ff);

      // Floor rounding of a negative quotient takes the next magnitude up
      q_inc = div_q + 64'(div_rnz);
      q_sel = neg_ff ? q_inc : div_q;
      mag_c = (q_sel > SAT48) ? SAT48 : q_sel;
      q_m   = q_sel[52:0];

      start_c = (start_ff < 0) ? 53'sd0 : start_ff;
      stop_c  = (stop_ff > 53'(DETECTOR_ROWS - 1)) ?
                53'(DETECTOR_ROWS - 1) : stop_ff;
      span    = stop_c - start_c;

      g_sel  = (cmd.pp == 2'd0) ? f_ff[23:0] : f_ff[47:24];
      g_prod = 55'(gain_ff) * 55'(g_sel);

      wd   = 54'(wfc_ff) + $signed(54'(41'(row_ff) * 41'(dd_ff)));
      diff = wd - 54'(c_ff);
      d2   = (diff < 0) ? -(diff <<< 1) : (diff <<< 1);
      b2   = $signed(54'(wid_ff)) - $signed(54'(dd_ff));
      b2   = (b2 < 0) ? -b2 : b2;
      m    = (b2 > d2) ? b2 : d2;
      l2   = $signed(54'(wid_ff)) + $signed(54'(dd_ff)) - m;

      pa     = cmd.pp[1] ? 21'(p41_ff[40:21]) : p41_ff[20:0];
      pb     = cmd.pp[0] ? 21'(l2_ff[40:21]) : l2_ff[20:0];
      m_prod = 42'(pa) * 42'(pb);
      unique case (cmd.pp)
         2'd0:    m_term = 82'(m_prod);
         2'd3:    m_term = 82'(m_prod) << 42;
         default: m_term = 82'(m_prod) << 21;
      endcase

      // Round half up, saturate at the top code
      w_sum = 83'(macc_ff) + 83'(64'h1_0000_0000);
      if (l2_zero_ff || p_zero_ff) begin
         weight_val = '0;
      end else if (p_sat_ff || l2_sat_ff || (|w_sum[82:41])) begin
         weight_val = '1;
      end else begin
         weight_val = w_sum[40:33];
      end

      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = 32'(du_ff);
      unique case (cmd.op)
         afwg_pkg::OP_DIV_C: begin
            div_start = 1'b1;
            div_dvd   = prod_a_ff[63] ? 64'(-prod_a_ff) : 64'(prod_a_ff);
         end
         afwg_pkg::OP_DIV_W: begin
            div_start = 1'b1;
            div_dvd   = 64'(prod_b_ff);
         end
         afwg_pkg::OP_DIV_S: begin
            div_start = 1'b1;
            div_dvd   = 64'(num_s_ff[52] ? -num_s_ff : num_s_ff);
            div_dvs   = {dd_ff, 1'b0};
         end
         afwg_pkg::OP_DIV_P: begin
            div_start = 1'b1;
            div_dvd   = 64'(num_p_ff[52] ? -num_p_ff : num_p_ff);
            div_dvs   = {dd_ff, 1'b0};
         end
         afwg_pkg::OP_DIV_F: begin
            div_start = 1'b1;
            div_dvd   = {16'h0, sqrt_root, 16'h0};
         end
         default: ;
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         uro_ff    <= '0;
         du_cfg_ff <= 31'd65536;
         sdd_ff    <= 31'd65536;
         zo_ff     <= '0;
         dz_ff     <= 31'd65536;
         wfc_ff    <= '0;
         dd_ff     <= 31'd65536;
         gain_ff   <= 31'd65536;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            afwg_pkg::REG_U_REL_ORIGIN: uro_ff    <= $signed(csr_wdata);
            afwg_pkg::REG_DELTA_U:      du_cfg_ff <= csr_wdata[30:0];
            afwg_pkg::REG_SRC_DET_DIST: sdd_ff    <= csr_wdata[30:0];
            afwg_pkg::REG_Z_ORIGIN:     zo_ff     <= $signed(csr_wdata);
            afwg_pkg::REG_DELTA_Z:      dz_ff     <= csr_wdata[30:0];
            afwg_pkg::REG_W_FIRST_CTR:  wfc_ff    <= $signed(csr_wdata);
            afwg_pkg::REG_DELTA_DW:     dd_ff     <= csr_wdata[30:0];
            afwg_pkg::REG_WEIGHT_GAIN:  gain_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Working registers, loaded on command
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         afwg_pkg::OP_LOAD: begin
            col_ff   <= in_col;
            slice_ff <= in_slice;
         end
         afwg_pkg::OP_CALC0: begin
            du_raw_ff <= du_raw_in;
            wv_raw_ff <= wv_raw_in;
         end
         afwg_pkg::OP_CALC1: begin
            du_ff <= (du_raw_ff > 43'sd2147483647) ? 31'h7FFF_FFFF : du_raw_ff[30:0];
            if (wv_raw_ff > 43'sd2147483647) begin
               wv_ff <= 32'sh7FFF_FFFF;
            end else if (wv_raw_ff < -43'sd2147483648) begin
               wv_ff <= 32'sh8000_0000;
            end else begin
               wv_ff <= wv_raw_ff[31:0];
            end
         end
         afwg_pkg::OP_MUL: begin
            prod_a_ff <= prod_a_in;
            prod_b_ff <= 62'(sdd_ff) * 62'(dz_ff);
         end
         afwg_pkg::OP_SQ: begin
            sq_ff <= 64'(du_ff) * 64'(du_ff) + 64'(wa) * 64'(wa);
         end
         afwg_pkg::OP_DIV_C: neg_ff <= prod_a_ff[63];
         afwg_pkg::OP_DIV_W: neg_ff <= 1'b0;
         afwg_pkg::OP_DIV_S: neg_ff <= num_s_ff[52];
         afwg_pkg::OP_DIV_P: neg_ff <= num_p_ff[52];
         afwg_pkg::OP_DIV_F: neg_ff <= 1'b0;
         afwg_pkg::OP_TAKE_C: begin
            c_ff <= neg_ff ? -$signed(50'(mag_c)) : $signed(50'(mag_c));
         end
         afwg_pkg::OP_TAKE_W: begin
            wid_ff <= (div_q > SAT48) ? SAT48[48:0] : div_q[48:0];
         end
         afwg_pkg::OP_NUM: begin
            num_s_ff <= (53'(c_ff) <<< 1) - $signed(53'(wid_ff))
                        - (53'(wfc_ff) <<< 1) + $signed(53'(dd_ff));
            num_p_ff <= (53'(c_ff) <<< 1) + $signed(53'(wid_ff))
                        - (53'(wfc_ff) <<< 1) + $signed(53'(dd_ff));
         end
         afwg_pkg::OP_TAKE_S: start_ff <= neg_ff ? -$signed(q_m) : $signed(q_m);
         afwg_pkg::OP_TAKE_P: stop_ff  <= neg_ff ? -$signed(q_m) : $signed(q_m);
         afwg_pkg::OP_RANGE: begin
            row_ff <= start_c[9:0];
            end_ff <= (span >= 53'(RUN_CAP)) ?
                      10'(start_c + 53'(RUN_CAP - 1)) : stop_c[9:0];
         end
         afwg_pkg::OP_TAKE_F: f_ff <= div_q[47:0];
         afwg_pkg::OP_GAIN: begin
            if (cmd.pp == 2'd0) begin
               gacc_ff <= 79'(g_prod);
            end else begin
               gacc_ff <= gacc_ff + (79'(g_prod) << 24);
            end
         end
         afwg_pkg::OP_PCAP: begin
            p41_ff    <= gacc_ff[56:16];
            p_sat_ff  <= |gacc_ff[78:57];
            p_zero_ff <= (gacc_ff[78:16] == '0);
         end
         afwg_pkg::OP_ROW: begin
            l2_ff      <= l2[40:0];
            l2_sat_ff  <= (l2 > 54'sh1FF_FFFF_FFFF);
            l2_zero_ff <= (l2 <= 0);
         end
         afwg_pkg::OP_PMUL: begin
            macc_ff <= ((cmd.pp == 2'd0) ? 82'd0 : macc_ff) + m_term;
         end
         afwg_pkg::OP_EMIT: row_ff <= row_ff + 10'd1;
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == afwg_pkg::OP_EMIT || cmd.op == afwg_pkg::OP_EMPTY) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == afwg_pkg::OP_EMIT) begin
         rsp_row_ff    <= row_ff;
         rsp_weight_ff <= weight_val;
         rsp_empty_ff  <= 1'b0;
         rsp_last_ff   <= (row_ff == end_ff);
      end else if (cmd.op == afwg_pkg::OP_EMPTY) begin
         rsp_row_ff    <= '0;
         rsp_weight_ff <= '0;
         rsp_empty_ff  <= 1'b1;
         rsp_last_ff   <= 1'b1;
      end
   end

   always_comb begin
      st.bad = (du_raw_ff <= 0) || (dd_ff == '0)
               || (11'(col_ff) >= 11'(U_BINS))
               || (11'(slice_ff) >= 11'(SLICES));
      st.div_done    = div_done;
      st.sqrt_done   = sqrt_done;
      st.range_empty = start_c > stop_c;
      st.last_row    = (row_ff == end_ff);
      st.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_weight = rsp_weight_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== rtl/afwg_controller.sv =====
module afwg_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  afwg_pkg::status_type st,
   output afwg_pkg::cmd_type    cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CALC0   = 5'd1;
   localparam logic [4:0] S_CALC1   = 5'd2;
   localparam logic [4:0] S_MUL     = 5'd3;
   localparam logic [4:0] S_SQ      = 5'd4;
   localparam logic [4:0] S_DC_GO   = 5'd5;
   localparam logic [4:0] S_DC_WAIT = 5'd6;
   localparam logic [4:0] S_DW_GO   = 5'd7;
   localparam logic [4:0] S_DW_WAIT = 5'd8;
   localparam logic [4:0] S_NUM     = 5'd9;
   localparam logic [4:0] S_DS_GO   = 5'd10;
   localparam logic [4:0] S_DS_WAIT = 5'd11;
   localparam logic [4:0] S_DP_GO   = 5'd12;
   localparam logic [4:0] S_DP_WAIT = 5'd13;
   localparam logic [4:0] S_RANGE   = 5'd14;
   localparam logic [4:0] S_SQ_GO   = 5'd15;
   localparam logic [4:0] S_SQ_WAIT = 5'd16;
   localparam logic [4:0] S_DF_GO   = 5'd17;
   localparam logic [4:0] S_DF_WAIT = 5'd18;
   localparam logic [4:0] S_GAIN    = 5'd19;
   localparam logic [4:0] S_PCAP    = 5'd20;
   localparam logic [4:0] S_ROW     = 5'd21;
   localparam logic [4:0] S_PMUL    = 5'd22;
   localparam logic [4:0] S_EMIT    = 5'd23;
   localparam logic [4:0] S_EMPTY   = 5'd24;

   logic [4:0] state_ff, state_in;
   logic [1:0] pp_ff, pp_in;

   always_comb begin
      state_in  = state_ff;
      pp_in     = pp_ff;
      cmd.op    = afwg_pkg::OP_NONE;
      cmd.pp    = pp_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = afwg_pkg::OP_LOAD;
               state_in = S_CALC0;
            end
         end
         S_CALC0: begin
            cmd.op   = afwg_pkg::OP_CALC0;
            state_in = S_CALC1;
         end
         S_CALC1: begin
            cmd.op   = afwg_pkg::OP_CALC1;
            state_in = st.bad ? S_EMPTY : S_MUL;
         end
         S_MUL: begin
            cmd.op   = afwg_pkg::OP_MUL;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op   = afwg_pkg::OP_SQ;
            state_in = S_DC_GO;
         end
         S_DC_GO: begin
            cmd.op   = afwg_pkg::OP_DIV_C;
            state_in = S_DC_WAIT;
         end
         S_DC_WAIT: begin
            if (st.div_done) begin
               cmd.op   = afwg_pkg::OP_TAKE_C;
               state_in = S_DW_GO;
            end
         end
         S_DW_GO: begin
            cmd.op   = afwg_pkg::OP_DIV_W;
            state_in = S_DW_WAIT;
         end
         S_DW_WAIT: begin
            if (st.div_done) begin
               cmd.op   = afwg_pkg::OP_TAKE_W;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            cmd.op   = afwg_pkg::OP_NUM;
            state_in = S_DS_GO;
         end
         S_DS_GO: begin
            cmd.op   = afwg_pkg::OP_DIV_S;
            state_in = S_DS_WAIT;
         end
         S_DS_WAIT: begin
            if (st.div_done) begin
               cmd.op   = afwg_pkg::OP_TAKE_S;
               state_in = S_DP_GO;
            end
         end
         S_DP_GO: begin
            cmd.op   = afwg_pkg::OP_DIV_P;
            state_in = S_DP_WAIT;
         end
         S_DP_WAIT: begin
            if (st.div_done) begin
               cmd.op   = afwg_pkg::OP_TAKE_P;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (st.range_empty) begin
               state_in = S_EMPTY;
            end else begin
               cmd.op   = afwg_pkg::OP_RANGE;
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO: begin
            cmd.op   = afwg_pkg::OP_SQRT;
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (st.sqrt_done) begin
               state_in = S_DF_GO;
            end
         end
         S_DF_GO: begin
            cmd.op   = afwg_pkg::OP_DIV_F;
            state_in = S_DF_WAIT;
         end
         S_DF_WAIT: begin
            if (st.div_done) begin
               cmd.op   = afwg_pkg::OP_TAKE_F;
               pp_in    = 2'd0;
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.op = afwg_pkg::OP_GAIN;
            if (pp_ff == 2'd1) begin
               pp_in    = 2'd0;
               state_in = S_PCAP;
            end else begin
               pp_in = pp_ff + 2'd1;
            end
         end
         S_PCAP: begin
            cmd.op   = afwg_pkg::OP_PCAP;
            state_in = S_ROW;
         end
         S_ROW: begin
            cmd.op   = afwg_pkg::OP_ROW;
            pp_in    = 2'd0;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            cmd.op = afwg_pkg::OP_PMUL;
            if (pp_ff == 2'd3) begin
               pp_in    = 2'd0;
               state_in = S_EMIT;
            end else begin
               pp_in = pp_ff + 2'd1;
            end
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.op   = afwg_pkg::OP_EMIT;
               state_in = st.last_row ? S_IDLE : S_ROW;
            end
         end
         S_EMPTY: begin
            if (st.out_free) begin
               cmd.op   = afwg_pkg::OP_EMPTY;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pp_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         pp_ff    <= pp_in;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // One row word as the block reports it
   typedef struct {
      logic [afwg_pkg::ROW_W-1:0]    row;
      logic [afwg_pkg::WEIGHT_W-1:0] weight;
      logic                          empty;
      logic                          last;
   } row_word_type;

   localparam logic STEP_WRITE = 1'b0;
   localparam logic STEP_VOXEL = 1'b1;

   // Directed stimulus: register writes and voxels, a few with a typed-in answer
   typedef struct {
      logic                           kind;
      logic [afwg_pkg::CFG_IDX_W-1:0] idx;
      logic [31:0]                    val;
      logic [afwg_pkg::COL_W-1:0]     col;
      logic [afwg_pkg::COL_W-1:0]     slc;
      bit                             typed;
      row_word_type                   answer;
   } step_type;

   localparam longint SAT48   = 64'sd1 <<< 48;
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483648;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [9:0] voxel_column, [19:10] voxel_slice, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [9:0] detector_row, [17:10] weight, rest zero
   logic        rsp_tuser;   // [0] empty_res
   logic        rsp_tlast;

   // Shadow copy of the geometry registers
   longint u_origin, z_orig, w_first, du_step, src_det, dz_step, row_pitch, gain;

   row_word_type pending_rows[$];
   int           errors;
   int           burst_left;
   bit           hold_request;
   bit           csr_busy;

   axial_footprint_weight_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop for a hung block
   initial begin
      #8ms;
      $display("Verification failed");
      $finish;
   end

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Floor division for a positive divisor
   function automatic longint floor_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Gain times obliquity times twice the overlap, rounded and saturated
   function automatic logic [7:0] row_weight(input longint unsigned f, input longint unsigned l2);
      longint unsigned g, p, w;
      g = longint'(gain);
      if (l2 == 0 || g == 0 || f == 0) return 8'd0;
      if (g > 64'hFFFF_FFFF_FFFF_FFFF / f) return 8'd255;
      p = (g * f) >> 16;
      if (p > 64'h8000_0000_0000_0000 / l2) return 8'd255;
      w = (p * l2 + 64'h1_0000_0000) >> 33;
      return (w > 255) ? 8'd255 : w[7:0];
   endfunction

   function automatic void push_empty();
      row_word_type e;
      e.row = '0; e.weight = '0; e.empty = 1'b1; e.last = 1'b1;
      pending_rows.push_back(e);
   endfunction

   // Work out the rows and weights one voxel covers
   function automatic void predict_footprint(input logic [9:0] col, input logic [9:0] slc);
      longint cv, sv, du, wv, c, wid, first, stop, count, row, d2, b2, m, l2;
      longint unsigned sq, wa, f;
      row_word_type e;
      cv = col;
      sv = slc;
      du = u_origin + cv * du_step;
      if (du <= 0 || row_pitch == 0) begin
         push_empty();
         return;
      end
      du = clip(du, 1, I32_MAX);
      wv = clip(z_orig + sv * dz_step + (dz_step >>> 1), I32_MIN, I32_MAX);
      c = clip(floor_quot(src_det * wv, du), -SAT48, SAT48);
      wid = clip((src_det * dz_step) / du, 0, SAT48);
      first = floor_quot(2 * c - wid - 2 * w_first + row_pitch, 2 * row_pitch);
      stop = floor_quot(2 * c + wid - 2 * w_first + row_pitch, 2 * row_pitch);
      if (first < 0) first = 0;
      if (stop > afwg_pkg::DETECTOR_ROWS - 1) stop = afwg_pkg::DETECTOR_ROWS - 1;
      if (first > stop) begin
         push_empty();
         return;
      end
      count = stop - first + 1;
      if (count > afwg_pkg::RUN_CAP) count = afwg_pkg::RUN_CAP;
      wa = (wv < 0) ? -wv : wv;
      sq = longint'(du) * longint'(du) + wa * wa;
      f = (root_floor(sq) << 16) / longint'(du);
      for (longint k = 0; k < count; k++) begin
         row = first + k;
         d2 = 2 * (w_first + row * row_pitch - c);
         b2 = wid - row_pitch;
         if (d2 < 0) d2 = -d2;
         if (b2 < 0) b2 = -b2;
         m = (b2 > d2) ? b2 : d2;
         l2 = (wid + row_pitch) - m;
         if (l2 < 0) l2 = 0;
         e.row = row[9:0];
         e.weight = row_weight(f, l2);
         e.empty = 1'b0;
         e.last = (k == count - 1);
         pending_rows.push_back(e);
      end
   endfunction

   // Drive one register write; the caller drops the enable after the last one
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         afwg_pkg::REG_U_REL_ORIGIN: u_origin  = longint'($signed(val));
         afwg_pkg::REG_DELTA_U:      du_step   = longint'({33'd0, val[30:0]});
         afwg_pkg::REG_SRC_DET_DIST: src_det   = longint'({33'd0, val[30:0]});
         afwg_pkg::REG_Z_ORIGIN:     z_orig    = longint'($signed(val));
         afwg_pkg::REG_DELTA_Z:      dz_step   = longint'({33'd0, val[30:0]});
         afwg_pkg::REG_W_FIRST_CTR:  w_first   = longint'($signed(val));
         afwg_pkg::REG_DELTA_DW:     row_pitch = longint'({33'd0, val[30:0]});
         afwg_pkg::REG_WEIGHT_GAIN:  gain      = longint'({33'd0, val[30:0]});
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Wait until every row word has come back, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Offer one voxel word, in bursts separated by random gaps
   task automatic send_voxel(input logic [9:0] col, input logic [9:0] slc,
                             input bit typed, input row_word_type answer);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, slc, col};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (typed) pending_rows.push_back(answer);
      else predict_footprint(col, slc);
   endtask

   // Receiver: shifting stall pattern, plus one long hold-off on request
   initial begin
      int mode, left;
      rsp_tready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_request = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(16, 128);
         end
         left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Compare every accepted row word with the oldest expectation
   always @(posedge clock) begin
      row_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rows.size() == 0) begin
            report($sformatf("unexpected word row %0d", rsp_tdata[9:0]));
         end else begin
            e = pending_rows.pop_front();
            if (rsp_tdata[9:0] !== e.row)
               report($sformatf("row %0d, want %0d", rsp_tdata[9:0], e.row));
            if (rsp_tdata[17:10] !== e.weight)
               report($sformatf("weight %0d at row %0d, want %0d",
                                rsp_tdata[17:10], e.row, e.weight));
            if (rsp_tuser !== e.empty)
               report($sformatf("empty flag %b, want %b", rsp_tuser, e.empty));
            if (rsp_tlast !== e.last)
               report($sformatf("last %b at row %0d, want %b", rsp_tlast, e.row, e.last));
         end
      end
   end

   function automatic step_type wr(input logic [2:0] idx, input logic [31:0] val);
      step_type s;
      s = '{default: '0};
      s.kind = STEP_WRITE; s.idx = idx; s.val = val;
      return s;
   endfunction

   function automatic step_type vox(input logic [9:0] col, input logic [9:0] slc,
                                    input bit typed);
      step_type s;
      s = '{default: '0};
      s.kind = STEP_VOXEL; s.col = col; s.slc = slc; s.typed = typed;
      // the only typed answer is the lone empty word
      s.answer.empty = typed; s.answer.last = typed;
      return s;
   endfunction

   // Fold a signed value into a register word
   function automatic logic [31:0] as_word(input longint v);
      return v[31:0];
   endfunction

   initial begin
      step_type     plan[$];
      row_word_type none;
      logic [31:0]  regs[8];
      longint       pitch, dz;
      errors       = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      csr_busy     = 1'b0;
      none         = '{default: '0};
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      // defaults after reset
      u_origin = 0; du_step = 65536; src_det = 65536; z_orig = 0;
      dz_step = 65536; w_first = 0; row_pitch = 65536; gain = 65536;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed part: defaults, zero pitch, voxel behind the source, extremes, long run
      plan = '{
         vox(10'd0, 10'd0, 1),          // column 0 sits on the source: empty
         vox(10'd1, 10'd0, 0),
         vox(10'd1023, 10'd1023, 0),
         vox(10'h2AA, 10'h155, 0),
         vox(10'h155, 10'h2AA, 0),
         wr(afwg_pkg::REG_DELTA_DW, 32'h0000_0000),
         vox(10'd5, 10'd5, 1),          // zero row pitch: empty
         wr(afwg_pkg::REG_DELTA_DW, 32'h0001_0000),
         wr(afwg_pkg::REG_U_REL_ORIGIN, 32'h8000_0000),
         vox(10'd0, 10'd7, 1),          // behind the source: empty
         vox(10'd1023, 10'd0, 1),
         wr(afwg_pkg::REG_U_REL_ORIGIN, 32'h7FFF_FFFF),
         vox(10'd1023, 10'd1023, 0),
         vox(10'd0, 10'd0, 0),
         wr(afwg_pkg::REG_WEIGHT_GAIN, 32'h0000_0000),
         vox(10'd3, 10'd3, 0),
         wr(afwg_pkg::REG_WEIGHT_GAIN, 32'hFFFF_FFFF),
         wr(afwg_pkg::REG_DELTA_Z, 32'h7FFF_FFFF),
         wr(afwg_pkg::REG_Z_ORIGIN, 32'h8000_0000),
         wr(afwg_pkg::REG_W_FIRST_CTR, 32'h7FFF_FFFF),
         wr(afwg_pkg::REG_SRC_DET_DIST, 32'h7FFF_FFFF),
         wr(afwg_pkg::REG_DELTA_U, 32'h7FFF_FFFF),
         vox(10'd0, 10'd0, 0),
         vox(10'd1023, 10'd1023, 0),
         vox(10'd512, 10'd511, 0),
         // wide footprint: more rows than one run holds
         wr(afwg_pkg::REG_U_REL_ORIGIN, 32'h0001_0000),
         wr(afwg_pkg::REG_DELTA_U, 32'h0001_0000),
         wr(afwg_pkg::REG_SRC_DET_DIST, 32'h0010_0000),
         wr(afwg_pkg::REG_Z_ORIGIN, 32'h0000_0000),
         wr(afwg_pkg::REG_DELTA_Z, 32'h0004_0000),
         wr(afwg_pkg::REG_W_FIRST_CTR, 32'h0000_0000),
         wr(afwg_pkg::REG_DELTA_DW, 32'h0001_0000),
         wr(afwg_pkg::REG_WEIGHT_GAIN, 32'h0002_0000),
         vox(10'd0, 10'd10, 0),
         vox(10'd0, 10'd0, 0),
         vox(10'd2, 10'd40, 0)
      };
      foreach (plan[i]) begin
         if (plan[i].kind == STEP_WRITE) begin
            if (!csr_busy) drain();
            write_reg(plan[i].idx, plan[i].val);
            csr_busy = 1'b1;
         end else begin
            if (csr_busy) csr_wr_en <= 1'b0;
            csr_busy = 1'b0;
            send_voxel(plan[i].col, plan[i].slc, plan[i].typed, plan[i].answer);
         end
      end

      // Random part: several geometries, the first two at the register extremes
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         if (ph == 0) begin
            regs = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
         end else if (ph == 1) begin
            regs = '{32'h0000_0001, 32'h0000_0001, 32'h8000_0001, 32'h8000_0000,
                     32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001};
         end else begin
            pitch = $urandom_range(32'h4000, 32'h40000);
            dz    = $urandom_range(32'h1000, 32'h20000);
            regs[afwg_pkg::REG_U_REL_ORIGIN] = ($urandom_range(0, 3) == 0)
               ? as_word(-longint'($urandom_range(0, 32'h0200_0000)))
               : $urandom_range(32'h1000, 32'h0080_0000);
            regs[afwg_pkg::REG_DELTA_U]      =
               {1'($urandom), 31'($urandom_range(32'h400, 32'h20000))};
            regs[afwg_pkg::REG_SRC_DET_DIST] =
               {1'($urandom), 31'($urandom_range(32'h10000, 32'h4000000))};
            regs[afwg_pkg::REG_Z_ORIGIN]     = as_word(-512 * dz + $urandom_range(0, 32'h40000));
            regs[afwg_pkg::REG_DELTA_Z]      = {1'($urandom), 31'(dz)};
            regs[afwg_pkg::REG_W_FIRST_CTR]  =
               as_word(-longint'($urandom_range(100, 900)) * pitch);
            regs[afwg_pkg::REG_DELTA_DW]     = {1'($urandom), 31'(pitch)};
            regs[afwg_pkg::REG_WEIGHT_GAIN]  =
               {1'($urandom), 31'($urandom_range(0, 32'h0040_0000))};
         end
         for (int r = 0; r < 8; r++) write_reg(3'(r), regs[r]);
         csr_wr_en <= 1'b0;
         // hold the receiver off for a long stretch while voxels keep coming
         if (ph == 3) hold_request = 1'b1;
         for (int n = 0; n < 19; n++)
            send_voxel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 0, none);
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== axial_footprint_weight_generator_unit.f =====
rtl/afwg_pkg.sv
rtl/afwg_divider.sv
rtl/afwg_isqrt.sv
rtl/afwg_datapath.sv
rtl/afwg_controller.sv
rtl/axial_footprint_weight_generator_unit.sv
tb/testbench.sv
